// File: sv/sorted_timer_expiry_queue_macros.svh
// Assertion macros for the timer queue.
`ifndef SORTED_TIMER_EXPIRY_QUEUE_MACROS_SVH
`define SORTED_TIMER_EXPIRY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define STQ_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define STQ_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define STQ_ASSERT_IMP(label, clk, rst_n, a, c)
`define STQ_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// File: sv/stq_pkg.sv
// Shared types and constants for the timer queue.
`timescale 1ns / 1ps
package stq_pkg;
  localparam int NUM_TIMERS  = 16;
  localparam int DELAY_WIDTH = 32;
  localparam int IDW  = 4;
  localparam int TW   = 48;
  localparam int CW   = $clog2(NUM_TIMERS + 1);
  localparam int QIW  = $clog2(NUM_TIMERS);

  localparam logic [1:0] CMD_ARM = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [2:0] KIND_ARMED = 3'd0;
  localparam logic [2:0] KIND_CANCELLED = 3'd1;
  localparam logic [2:0] KIND_EXPIRED = 3'd2;
  localparam logic [2:0] KIND_REMAIN = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture input beat
    logic tick_now;    // now += 1
    logic scan_clr;    // reset scan index
    logic scan_inc;    // advance scan index
    logic rm_shift;    // shift entry at scan index down by one (removal)
    logic rm_done;     // queue_count--, clear pending
    logic ins_start;   // prepare insert of cur id
    logic ins_step;    // one step of backwards shift-insert
    logic exp_pop;     // pop head entry as expired
    logic rq_pop;      // pop next re-arm candidate
    logic set_period;  // write period/repeat for arm
    logic out_load;    // load output register
    logic [2:0] out_kind;
    logic out_last;
  } stq_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic id_ok;
    logic pending;     // cur timer pending
    logic scan_end;    // scan index reached count
    logic scan_hit;    // entry at scan index is cur id
    logic head_due;    // head exists and expires before now
    logic ins_full;    // queue full
    logic ins_here;    // insert position found
    logic rq_any;      // re-arm list non-empty
    logic rq_rep;      // candidate repeats
  } stq_sts_t;
endpackage

// File: sv/sorted_timer_expiry_queue.sv
// Sorted timer expiry queue: 16 timers in one expiry-ordered list.
// One command at a time; the queue walk (one entry a cycle) sets the
// rate. Synchronous active-low reset clears tick counter, count, pending
// and repeat marks; queue contents need no clearing.
`timescale 1ns / 1ps
`include "sorted_timer_expiry_queue_macros.svh"
module sorted_timer_expiry_queue import stq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_timer_id,
  input  logic [31:0] in_delay,
  input  logic        in_repeat_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_timer_id_res,
  output logic [31:0] out_remaining,
  output logic        out_last
);
  stq_cmd_t cmd;
  stq_sts_t sts;
  logic busy, out_valid_r;

  stq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_full(out_valid_r && out_stall),
    .cmd, .sts, .busy
  );
  stq_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_command, .in_timer_id, .in_delay, .in_repeat_req,
    .res_kind(out_kind), .res_id(out_timer_id_res), .res_remaining(out_remaining),
    .res_last(out_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end
  assign out_valid = out_valid_r;

  `STQ_ASSERT_IMP(a_idle_stall, clk, rst_n, !busy, !in_stall)
  `STQ_ASSERT_NXT(a_load_valid, clk, rst_n, cmd.out_load, out_valid)
  `STQ_ASSERT_IMP(a_no_overrun, clk, rst_n, out_valid && out_stall, !cmd.out_load)
endmodule

// File: sv/stq_datapath.sv
// Queue storage, tick counter and result formation for the timer queue.
`timescale 1ns / 1ps
module stq_datapath import stq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  stq_cmd_t         cmd,
  output stq_sts_t         sts,
  input  logic [1:0]       in_command,
  input  logic [IDW-1:0]   in_timer_id,
  input  logic [31:0]      in_delay,
  input  logic             in_repeat_req,
  output logic [2:0]       res_kind,
  output logic [IDW-1:0]   res_id,
  output logic [31:0]      res_remaining,
  output logic             res_last
);
  logic [IDW-1:0] q_id_r [NUM_TIMERS];
  logic [TW-1:0]  q_exp_r [NUM_TIMERS];
  logic [DELAY_WIDTH-1:0] period_r [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] rep_r, pend_r;
  logic [CW-1:0]  cnt_r;
  logic [TW-1:0]  now_r;
  logic [1:0]     cmd_r;
  logic [IDW-1:0] id_r;
  logic [DELAY_WIDTH-1:0] dly_r;
  logic           rq_r;
  logic [CW-1:0]  idx_r;
  logic [TW-1:0]  exp_r;
  logic [31:0]    rem_r;
  // ids popped during this tick, in report order, for re-arming
  logic [IDW-1:0] due_r [NUM_TIMERS];
  logic [CW-1:0]  due_n_r, due_rd_r;
  logic [QIW-1:0] ix, ixm;
  logic [QIW-1:0] cid;
  logic [TW-1:0]  left;

  assign ix  = idx_r[QIW-1:0];
  assign ixm = ix - QIW'(1);
  assign cid = id_r[QIW-1:0];
  assign left = (q_exp_r[ix] > now_r) ? q_exp_r[ix] - now_r : '0;

  always_comb begin
    sts.cmd      = cmd_r;
    sts.id_ok    = ({1'b0, id_r} < (IDW+1)'(NUM_TIMERS));
    sts.pending  = pend_r[cid];
    sts.scan_end = (idx_r >= cnt_r);
    sts.scan_hit = (q_id_r[ix] == id_r);
    sts.head_due = (cnt_r != '0) && (q_exp_r[0] < now_r);
    sts.ins_full = (cnt_r >= CW'(NUM_TIMERS));
    sts.ins_here = (idx_r == '0) || !(q_exp_r[ixm] > exp_r);
    sts.rq_any   = (due_rd_r < due_n_r);
    sts.rq_rep   = rep_r[due_r[due_rd_r[QIW-1:0]][QIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      id_r  <= in_timer_id;
      dly_r <= in_delay[DELAY_WIDTH-1:0];
      rq_r  <= in_repeat_req;
    end
    if (cmd.set_period) period_r[cid] <= dly_r;
    if (cmd.scan_clr) idx_r <= '0;
    else if (cmd.scan_inc) idx_r <= idx_r + CW'(1);
    if (cmd.scan_inc && !sts.scan_end && sts.scan_hit) rem_r <= (left > 48'hFFFF_FFFF)
      ? 32'hFFFF_FFFF : left[31:0];
    if (cmd.rm_shift) begin
      q_id_r[ix]  <= q_id_r[ix + QIW'(1)];
      q_exp_r[ix] <= q_exp_r[ix + QIW'(1)];
    end
    if (cmd.ins_start) begin
      idx_r <= cnt_r;
      exp_r <= now_r + TW'(dly_r);
    end
    if (cmd.ins_step) begin
      if (sts.ins_here) begin
        q_id_r[ix]  <= id_r;
        q_exp_r[ix] <= exp_r;
      end else begin
        q_id_r[ix]  <= q_id_r[ixm];
        q_exp_r[ix] <= q_exp_r[ixm];
        idx_r <= idx_r - CW'(1);
      end
    end
    if (cmd.exp_pop) begin
      for (int i = 0; i < NUM_TIMERS - 1; i++) begin
        q_id_r[i]  <= q_id_r[i+1];
        q_exp_r[i] <= q_exp_r[i+1];
      end
      due_r[due_n_r[QIW-1:0]] <= q_id_r[0];
      id_r <= q_id_r[0];
    end
    if (cmd.rq_pop) begin
      id_r  <= due_r[due_rd_r[QIW-1:0]];
      dly_r <= period_r[due_r[due_rd_r[QIW-1:0]][QIW-1:0]];
    end
    if (cmd.out_load) begin
      res_kind <= cmd.out_kind;
      res_last <= cmd.out_last;
      // an expired beat reports the head being popped in the same cycle
      res_id   <= (cmd.out_kind == KIND_DONE) ? '0 :
                  (cmd.out_kind == KIND_EXPIRED) ? q_id_r[0] : id_r;
      res_remaining <= (cmd.out_kind == KIND_ARMED) ? 32'(dly_r) :
                       (cmd.out_kind == KIND_REMAIN && sts.id_ok && pend_r[cid]) ? rem_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0; cnt_r <= '0; rep_r <= '0; pend_r <= '0;
      due_n_r <= '0; due_rd_r <= '0;
    end else begin
      if (cmd.tick_now) begin
        now_r <= now_r + TW'(1);
        due_n_r <= '0; due_rd_r <= '0;
      end
      if (cmd.set_period) rep_r[cid] <= rq_r;
      if (cmd.rm_done) begin
        cnt_r <= cnt_r - CW'(1);
        pend_r[cid] <= 1'b0;
      end
      if (cmd.ins_step && sts.ins_here) begin
        cnt_r <= cnt_r + CW'(1);
        pend_r[cid] <= 1'b1;
      end
      if (cmd.exp_pop) begin
        cnt_r <= cnt_r - CW'(1);
        pend_r[q_id_r[0][QIW-1:0]] <= 1'b0;
        due_n_r <= due_n_r + CW'(1);
      end
      if (cmd.rq_pop) due_rd_r <= due_rd_r + CW'(1);
    end
  end
endmodule

// File: sv/stq_ctrl.sv
// Sequencer for the timer queue commands.
`timescale 1ns / 1ps
module stq_ctrl import stq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_full,
  output stq_cmd_t cmd,
  input  stq_sts_t sts,
  output logic     busy
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DEC  = 10'b0000000010,
    S_FIND = 10'b0000000100,
    S_SHFT = 10'b0000001000,
    S_INS0 = 10'b0000010000,
    S_INS  = 10'b0000100000,
    S_RES  = 10'b0001000000,
    S_EXP  = 10'b0010000000,
    S_RQ   = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;
  state_t state_r, state_nxt;
  // rearm_r: the current removal/insert belongs to a tick re-arm
  logic rearm_r, rearm_nxt;

  assign busy = (state_r != S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    rearm_nxt = rearm_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.scan_clr = 1'b1;
        rearm_nxt = 1'b0;
        case (sts.cmd)
          CMD_TICK: begin
            cmd.tick_now = 1'b1;
            state_nxt = S_EXP;
          end
          CMD_ARM: begin
            if (sts.id_ok) cmd.set_period = 1'b1;
            state_nxt = sts.id_ok ? S_FIND : S_RES;
          end
          default: state_nxt = sts.id_ok ? S_FIND : S_RES;
        endcase
      end
      S_FIND: begin
        if (!sts.pending || sts.scan_end) begin
          if (sts.cmd == CMD_ARM || rearm_r) state_nxt = S_INS0;
          else state_nxt = S_RES;
        end else if (sts.scan_hit) begin
          if (sts.cmd == CMD_QUERY) begin
            cmd.scan_inc = 1'b1;
            state_nxt = S_RES;
          end else state_nxt = S_SHFT;
        end else cmd.scan_inc = 1'b1;
      end
      S_SHFT: begin
        if (sts.scan_end) begin
          cmd.rm_done = 1'b1;
          state_nxt = (sts.cmd == CMD_ARM || rearm_r) ? S_INS0 : S_RES;
        end else begin
          cmd.rm_shift = 1'b1;
          cmd.scan_inc = 1'b1;
        end
      end
      S_INS0: begin
        if (sts.ins_full) state_nxt = rearm_r ? S_RQ : S_RES;
        else begin
          cmd.ins_start = 1'b1;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        cmd.ins_step = 1'b1;
        if (sts.ins_here) state_nxt = rearm_r ? S_RQ : S_RES;
      end
      S_RES: begin
        if (!out_full) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          case (sts.cmd)
            CMD_ARM:   cmd.out_kind = sts.id_ok ? KIND_ARMED : KIND_CANCELLED;
            CMD_QUERY: cmd.out_kind = KIND_REMAIN;
            default:   cmd.out_kind = KIND_CANCELLED;
          endcase
          state_nxt = S_IDLE;
        end
      end
      S_EXP: begin
        if (sts.head_due) begin
          if (!out_full) begin
            cmd.exp_pop = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_kind = KIND_EXPIRED;
          end
        end else state_nxt = S_RQ;
      end
      S_RQ: begin
        rearm_nxt = 1'b1;
        if (!sts.rq_any) state_nxt = S_DONE;
        else begin
          cmd.rq_pop = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt = sts.rq_rep ? S_INS0 : S_RQ;
        end
      end
      S_DONE: begin
        if (!out_full) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_DONE;
          cmd.out_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rearm_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rearm_r <= rearm_nxt;
    end
  end
endmodule
